@@ sv/alert_led_ring_pattern_generator_unit_assert.svh @@
// ============================================================================
// Assertion macros for the alert LED ring pattern generator
// Clocked assertion shorthands used by the checker file.
// ============================================================================
`ifndef ALERT_LED_RING_PATTERN_GENERATOR_UNIT_ASSERT_SVH
`define ALERT_LED_RING_PATTERN_GENERATOR_UNIT_ASSERT_SVH

// Clocked assertion, disabled while reset is low.
`define ALRPG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define ALRPG_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/alrpg_pkg.sv @@
// ============================================================================
// alrpg_pkg
// Shared sizes, codes and types of the alert LED ring pattern generator.
// ============================================================================
`default_nettype none

package alrpg_pkg;

    localparam int METRIC_COUNT = 5;
    localparam int RING_SIZE    = 8;
    localparam int QUEUE_DEPTH  = 2;

    localparam int OP_W    = 2;
    localparam int MIDX_W  = 3;
    localparam int LVL_W   = 2;
    localparam int TICK_W  = 32;
    localparam int LED_W   = 4;
    localparam int RGB_W   = 24;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // chase pattern: one slot per 500 ms period fraction
    localparam int CHASE_STEP = 500;
    localparam int POS_W      = $clog2(CHASE_STEP * (RING_SIZE + 1) + 1);
    localparam int IDX_W      = $clog2(RING_SIZE + 1);

    localparam logic [OP_W-1:0] OP_SET    = 2'd0;
    localparam logic [OP_W-1:0] OP_ARM    = 2'd1;
    localparam logic [OP_W-1:0] OP_RENDER = 2'd2;

    localparam logic [LVL_W-1:0] LVL_NONE = 2'd0;
    localparam logic [LVL_W-1:0] LVL_WARN = 2'd1;
    localparam logic [LVL_W-1:0] LVL_CRIT = 2'd2;

    localparam logic [1:0] REG_AMBER = 2'd0;
    localparam logic [1:0] REG_RED   = 2'd1;
    localparam logic [1:0] REG_GREEN = 2'd2;

    localparam logic [RGB_W-1:0] AMBER_RESET = 24'hB4FF00;
    localparam logic [RGB_W-1:0] RED_RESET   = 24'h00FF00;
    localparam logic [RGB_W-1:0] GREEN_RESET = 24'hFF0000;

    typedef logic [RGB_W-1:0] t_rgb;

    typedef struct packed {
        t_rgb amber;
        t_rgb red;
        t_rgb green;
    } t_colors;

    typedef enum logic [1:0] {
        K_END,
        K_UNIFORM,
        K_HALVES,
        K_CHASE
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        t_rgb             ring_rgb;
        t_rgb             center_rgb;
        logic             phase;
        logic [POS_W-1:0] pos;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_push;

    typedef struct packed {
        logic avail;
        t_cmd cmd;
    } t_cmd_peek;

endpackage

`default_nettype wire

@@ sv/alrpg_req_if.sv @@
// ============================================================================
// alrpg_req_if
// Request channel: set level, arm pit flash, render at tick.
// ============================================================================
`default_nettype none

interface alrpg_req_if;
    import alrpg_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [MIDX_W-1:0] metric_index;
    logic [LVL_W-1:0]  level;
    logic [TICK_W-1:0] tick_ms;

    modport source (output valid, output op, output metric_index, output level,
                    output tick_ms, input ready);
    modport sink   (input valid, input op, input metric_index, input level,
                    input tick_ms, output ready);
endinterface

`default_nettype wire

@@ sv/alrpg_pix_if.sv @@
// ============================================================================
// alrpg_pix_if
// Pixel channel: one LED value per beat, frame_last on the final beat.
// ============================================================================
`default_nettype none

interface alrpg_pix_if;
    import alrpg_pkg::*;

    logic             valid;
    logic             ready;
    logic [LED_W-1:0] led_index;
    logic [7:0]       byte_first;
    logic [7:0]       byte_second;
    logic [7:0]       byte_third;
    logic             pixel_write;
    logic             frame_last;

    modport source (output valid, output led_index, output byte_first,
                    output byte_second, output byte_third, output pixel_write,
                    output frame_last, input ready);
    modport sink   (input valid, input led_index, input byte_first,
                    input byte_second, input byte_third, input pixel_write,
                    input frame_last, output ready);
endinterface

`default_nettype wire

@@ sv/alrpg_front.sv @@
// ============================================================================
// alrpg_front
// Accepts requests, keeps metric and pit state, classifies a render.
// ============================================================================
`default_nettype none

module alrpg_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    alrpg_req_if.sink            i_req,
    input  alrpg_pkg::t_colors   i_colors,
    input  logic                 i_q_full,
    output alrpg_pkg::t_cmd_push o_push
);
    import alrpg_pkg::*;

    localparam int PIT_PERIOD = 300;
    localparam int PIT_ON     = 150;
    localparam int PIT_CYCLES = 3;
    localparam int BLINK      = 125;
    localparam int TRI_PERIOD = 1000;
    localparam int TRI_HALF   = 500;
    localparam logic [28:0] DIV1000_MAGIC = 29'h10624DD3;
    localparam logic [12:0] DIV100_MAGIC  = 13'd5243;
    localparam logic [15:0] DIV255_MAGIC  = 16'd32897;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DIV  = 8'b0000_0010,
        ST_MOD  = 8'b0000_0100,
        ST_TRI  = 8'b0000_1000,
        ST_BRI  = 8'b0001_0000,
        ST_MUL  = 8'b0010_0000,
        ST_SCL  = 8'b0100_0000,
        ST_PUSH = 8'b1000_0000
    } t_state;

    typedef enum logic [2:0] {
        CLS_END,
        CLS_PIT,
        CLS_RC,
        CLS_OC,
        CLS_RW,
        CLS_OW,
        CLS_IDLE
    } t_cls;

    t_state            r_state, n_state;
    logic [LVL_W-1:0]  r_levels [METRIC_COUNT];
    logic              r_pit_active;
    logic              r_pit_started;
    logic [TICK_W-1:0] r_pit_start;

    logic [TICK_W-1:0] r_tick;
    t_cls              r_cls;
    logic              r_pit_on;
    logic [22:0]       r_q;
    logic [9:0]        r_p;
    logic [14:0]       r_x;
    logic [8:0]        r_m;
    logic [7:0]        r_b;
    logic [POS_W-1:0]  r_mr;
    logic [15:0]       r_y [3];
    t_rgb              r_sc;

    logic              acc;
    logic              rc, oc, rw, ow;
    logic [TICK_W-1:0] start, elapsed;
    logic              pit_done, pit_on;
    t_cls              cls;
    logic [60:0]       q_prod;
    logic [9:0]        tri_p;
    logic [27:0]       b_prod;
    logic [31:0]       sc_prod [3];
    logic              even;
    t_cmd              cmd;

    assign i_req.ready = (r_state == ST_IDLE);
    assign acc         = i_req.valid && i_req.ready;

    // classify from the current levels and the pit window
    always_comb begin
        rc = 1'b0;
        oc = 1'b0;
        rw = 1'b0;
        ow = 1'b0;
        for (int k = 0; k < METRIC_COUNT; k++) begin
            if (r_levels[k] == LVL_CRIT) begin
                if (k == 0) rc = 1'b1;
                else        oc = 1'b1;
            end else if (r_levels[k] == LVL_WARN) begin
                if (k == 0) rw = 1'b1;
                else        ow = 1'b1;
            end
        end
        start    = r_pit_started ? r_pit_start : i_req.tick_ms;
        elapsed  = i_req.tick_ms - start;
        pit_done = elapsed >= TICK_W'(PIT_PERIOD * PIT_CYCLES);
        pit_on   = 1'b0;
        for (int k = 0; k < PIT_CYCLES; k++) begin
            if (elapsed >= TICK_W'(k * PIT_PERIOD) &&
                elapsed <  TICK_W'(k * PIT_PERIOD + PIT_ON)) pit_on = 1'b1;
        end
        if (r_pit_active) cls = pit_done ? CLS_END : CLS_PIT;
        else if (rc)      cls = CLS_RC;
        else if (oc)      cls = CLS_OC;
        else if (rw)      cls = CLS_RW;
        else if (ow)      cls = CLS_OW;
        else              cls = CLS_IDLE;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (acc && i_req.op == OP_RENDER) n_state = ST_DIV;
            ST_DIV:  n_state = ST_MOD;
            ST_MOD:  n_state = ST_TRI;
            ST_TRI:  n_state = ST_BRI;
            ST_BRI:  n_state = ST_MUL;
            ST_MUL:  n_state = ST_SCL;
            ST_SCL:  n_state = ST_PUSH;
            ST_PUSH: if (!i_q_full) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_pit_active  <= 1'b0;
            r_pit_started <= 1'b0;
            r_pit_start   <= '0;
            for (int k = 0; k < METRIC_COUNT; k++) r_levels[k] <= LVL_NONE;
        end else begin
            r_state <= n_state;
            if (acc) begin
                case (i_req.op)
                    OP_SET: begin
                        if (4'(i_req.metric_index) < 4'(METRIC_COUNT) &&
                            i_req.level <= LVL_CRIT) begin
                            for (int k = 0; k < METRIC_COUNT; k++) begin
                                if (i_req.metric_index == MIDX_W'(k))
                                    r_levels[k] <= i_req.level;
                            end
                        end
                    end
                    OP_ARM: begin
                        r_pit_active  <= 1'b1;
                        r_pit_started <= 1'b0;
                    end
                    OP_RENDER: begin
                        if (r_pit_active) begin
                            if (!r_pit_started) begin
                                r_pit_started <= 1'b1;
                                r_pit_start   <= i_req.tick_ms;
                            end
                            if (pit_done) r_pit_active <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // arithmetic chain, one stage per state after the render is taken
    always_comb begin
        q_prod = 61'(r_tick) * 61'(DIV1000_MAGIC);
        tri_p  = (r_p < 10'(TRI_HALF)) ? r_p : 10'(TRI_PERIOD) - r_p;
        b_prod = 28'(r_x) * 28'(DIV100_MAGIC);
        for (int k = 0; k < 3; k++) sc_prod[k] = 32'(r_y[k]) * 32'(DIV255_MAGIC);
    end

    always_ff @(posedge i_clk) begin
        if (acc && i_req.op == OP_RENDER) begin
            r_tick   <= i_req.tick_ms;
            r_cls    <= cls;
            r_pit_on <= pit_on;
        end
        r_q  <= q_prod[60:38];
        r_p  <= 10'(r_tick - 32'(r_q) * 32'(TRI_PERIOD));
        r_x  <= 15'(tri_p) * 15'd51;
        r_m  <= (r_p >= 10'(TRI_HALF)) ? 9'(r_p - 10'(TRI_HALF)) : 9'(r_p);
        r_b  <= b_prod[26:19];
        r_mr <= POS_W'(r_m) * POS_W'(RING_SIZE);
        r_y[0] <= 16'(i_colors.amber[23:16]) * 16'(r_b);
        r_y[1] <= 16'(i_colors.amber[15:8])  * 16'(r_b);
        r_y[2] <= 16'(i_colors.amber[7:0])   * 16'(r_b);
        r_sc <= {sc_prod[0][30:23], sc_prod[1][30:23], sc_prod[2][30:23]};
    end

    // blink phase: tick/125 even, taken from tick mod 1000
    always_comb begin
        even = 1'b0;
        for (int k = 0; k < TRI_PERIOD / (2 * BLINK); k++) begin
            if (r_p >= 10'(2 * k * BLINK) && r_p < 10'(2 * k * BLINK + BLINK))
                even = 1'b1;
        end
        cmd.kind       = K_UNIFORM;
        cmd.ring_rgb   = '0;
        cmd.center_rgb = '0;
        cmd.phase      = even;
        cmd.pos        = r_mr;
        case (r_cls)
            CLS_END: cmd.kind = K_END;
            CLS_PIT: begin
                cmd.ring_rgb   = r_pit_on ? i_colors.green : '0;
                cmd.center_rgb = r_pit_on ? i_colors.green : '0;
            end
            CLS_RC: begin
                cmd.ring_rgb   = even ? i_colors.red : '0;
                cmd.center_rgb = i_colors.red;
            end
            CLS_OC: begin
                cmd.kind       = K_HALVES;
                cmd.ring_rgb   = i_colors.red;
                cmd.center_rgb = i_colors.red;
            end
            CLS_RW: cmd.ring_rgb = r_sc;
            CLS_OW: begin
                cmd.kind       = K_CHASE;
                cmd.ring_rgb   = i_colors.amber;
                cmd.center_rgb = i_colors.amber;
            end
            default: ;
        endcase
    end

    assign o_push.valid = (r_state == ST_PUSH);
    assign o_push.cmd   = cmd;

endmodule

`default_nettype wire

@@ sv/alrpg_cmd_queue.sv @@
// ============================================================================
// alrpg_cmd_queue
// Short FIFO of frame commands between the front and the pixel sequencer.
// ============================================================================
`default_nettype none

module alrpg_cmd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  alrpg_pkg::t_cmd_push i_push,
    output logic                 o_full,
    input  logic                 i_pop,
    output alrpg_pkg::t_cmd_peek o_peek
);
    import alrpg_pkg::*;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_push, do_pop;

    assign o_full       = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_peek.avail = (r_cnt != '0);
    assign o_peek.cmd   = r_mem[r_rd];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_peek.avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push)
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (do_pop)
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_push.cmd;
    end

endmodule

`default_nettype wire

@@ sv/alrpg_back.sv @@
// ============================================================================
// alrpg_back
// Pixel sequencer: walks a frame command into ring and center beats.
// ============================================================================
`default_nettype none

module alrpg_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  alrpg_pkg::t_cmd_peek i_peek,
    output logic                 o_pop,
    alrpg_pix_if.source          o_pix
);
    import alrpg_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_RUN  = 2'b10
    } t_bstate;

    t_bstate          r_bstate;
    t_cmd             r_cmd;
    logic [IDX_W-1:0] r_idx;
    logic [POS_W-1:0] r_lo;
    logic             r_ov;
    logic [LED_W-1:0] r_led;
    t_rgb             r_rgb;
    logic             r_pw, r_last;

    logic             slot_free, load, center, lit;
    logic [LED_W-1:0] px_idx;
    t_rgb             px_rgb;
    logic             px_pw, px_last;

    assign slot_free = !r_ov || o_pix.ready;
    assign load      = (r_bstate == B_RUN) && slot_free;
    assign o_pop     = (r_bstate == B_IDLE) && i_peek.avail;
    assign center    = (r_idx == IDX_W'(RING_SIZE));
    assign lit       = (r_cmd.pos >= r_lo) && (r_cmd.pos < r_lo + POS_W'(CHASE_STEP));

    always_comb begin
        px_idx  = LED_W'(r_idx);
        px_rgb  = '0;
        px_pw   = 1'b1;
        px_last = 1'b0;
        case (r_cmd.kind)
            K_END: begin
                px_idx  = '0;
                px_pw   = 1'b0;
                px_last = 1'b1;
            end
            K_UNIFORM: px_rgb = r_cmd.ring_rgb;
            K_HALVES: begin
                if ((r_idx < IDX_W'(RING_SIZE / 2)) == r_cmd.phase) px_rgb = r_cmd.ring_rgb;
            end
            K_CHASE: if (lit) px_rgb = r_cmd.ring_rgb;
            default: ;
        endcase
        if (center && r_cmd.kind != K_END) begin
            px_rgb  = r_cmd.center_rgb;
            px_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bstate <= B_IDLE;
            r_ov     <= 1'b0;
        end else begin
            if (load)             r_ov <= 1'b1;
            else if (o_pix.ready) r_ov <= 1'b0;
            case (r_bstate)
                B_IDLE:  if (i_peek.avail) r_bstate <= B_RUN;
                B_RUN:   if (load && px_last) r_bstate <= B_IDLE;
                default: r_bstate <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_peek.cmd;
            r_idx <= '0;
            r_lo  <= '0;
        end
        if (load) begin
            r_led  <= px_idx;
            r_rgb  <= px_rgb;
            r_pw   <= px_pw;
            r_last <= px_last;
            r_idx  <= r_idx + 1'b1;
            r_lo   <= r_lo + POS_W'(CHASE_STEP);
        end
    end

    assign o_pix.valid       = r_ov;
    assign o_pix.led_index   = r_led;
    assign o_pix.byte_first  = r_rgb[23:16];
    assign o_pix.byte_second = r_rgb[15:8];
    assign o_pix.byte_third  = r_rgb[7:0];
    assign o_pix.pixel_write = r_pw;
    assign o_pix.frame_last  = r_last;

endmodule

`default_nettype wire

@@ sv/alert_led_ring_pattern_generator_unit.sv @@
// ============================================================================
// alert_led_ring_pattern_generator_unit
// Alert level keeper and LED ring frame generator with an APB color map.
// ============================================================================
// Usage:
//   i_req carries one request per beat: set a metric level, arm the pit
//   flash, or render a frame at tick_ms. Set and arm beats leave ready high.
//   A render beat keeps ready low while the front works through its
//   arithmetic stages (mod 1000, triangle brightness, byte scaling) and
//   posts a frame command into a two-deep queue.
//   The pixel sequencer drains the queue into o_pix: 9 beats per frame,
//   ring LEDs 0..7 then the center LED with frame_last set. An ending pit
//   flash gives a single refresh-only beat instead.
//   Between frames the sequencer goes back to idle to pop the next command.
//   A stalled o_pix holds its beat; the queue keeps taking frame commands
//   until it fills, then the front waits with ready low.
//   Reset clears levels, pit state, queue and output valid, and restores the
//   reset colors. Colors are written over APB at 0x0, 0x4, 0x8; the user
//   must write them only while idle; the block itself does not enforce it.
// ============================================================================
`default_nettype none

module alert_led_ring_pattern_generator_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    alrpg_req_if.sink                    i_req,
    alrpg_pix_if.source                  o_pix,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [alrpg_pkg::ADDR_W-1:0] paddr,
    input  logic [alrpg_pkg::DATA_W-1:0] pwdata,
    output logic [alrpg_pkg::DATA_W-1:0] prdata,
    output logic                         pready
);
    import alrpg_pkg::*;

    t_colors   r_colors;
    logic      cfg_wr;
    t_cmd_push push;
    t_cmd_peek peek;
    logic      q_full, pop;

    // register file: write on the access phase of an APB write
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colors.amber <= AMBER_RESET;
            r_colors.red   <= RED_RESET;
            r_colors.green <= GREEN_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_AMBER: r_colors.amber <= pwdata[RGB_W-1:0];
                REG_RED:   r_colors.red   <= pwdata[RGB_W-1:0];
                REG_GREEN: r_colors.green <= pwdata[RGB_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_AMBER: prdata = DATA_W'(r_colors.amber);
            REG_RED:   prdata = DATA_W'(r_colors.red);
            REG_GREEN: prdata = DATA_W'(r_colors.green);
            default:   prdata = '0;
        endcase
    end

    // front: take requests, keep state, build frame commands
    alrpg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_colors (r_colors),
        .i_q_full (q_full),
        .o_push   (push)
    );

    // decouple request intake from pixel streaming
    alrpg_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_peek  (peek)
    );

    // back: advance one pixel per free output slot
    alrpg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_peek  (peek),
        .o_pop   (pop),
        .o_pix   (o_pix)
    );

endmodule

`default_nettype wire

@@ sv/alrpg_checker.sv @@
// ============================================================================
// alrpg_checker
// Port-level checks on the pixel stream of the pattern generator.
// ============================================================================
`default_nettype none
`include "alert_led_ring_pattern_generator_unit_assert.svh"

module alrpg_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    i_ready,
    input logic [alrpg_pkg::LED_W-1:0] i_led_index,
    input logic [7:0]              i_byte_first,
    input logic [7:0]              i_byte_second,
    input logic [7:0]              i_byte_third,
    input logic                    i_pixel_write,
    input logic                    i_frame_last
);
    import alrpg_pkg::*;

    `ALRPG_ASSERT(a_hold_valid, i_clk, i_rst_n, (i_valid && !i_ready) |=> i_valid, "beat dropped while stalled")
    `ALRPG_ASSERT(a_index_range, i_clk, i_rst_n, i_valid |-> (i_led_index <= LED_W'(RING_SIZE)), "led index out of range")
    `ALRPG_ASSERT(a_refresh_form, i_clk, i_rst_n, (i_valid && !i_pixel_write) |-> (i_frame_last && i_led_index == '0 && i_byte_first == '0 && i_byte_second == '0 && i_byte_third == '0), "bad refresh-only beat")
    `ALRPG_ASSERT(a_last_center, i_clk, i_rst_n, (i_valid && i_pixel_write && i_frame_last) |-> (i_led_index == LED_W'(RING_SIZE)), "frame ends off the center LED")
    `ALRPG_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_valid, "output valid after reset")

endmodule

bind alert_led_ring_pattern_generator_unit alrpg_checker u_alrpg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_pix.valid),
    .i_ready       (o_pix.ready),
    .i_led_index   (o_pix.led_index),
    .i_byte_first  (o_pix.byte_first),
    .i_byte_second (o_pix.byte_second),
    .i_byte_third  (o_pix.byte_third),
    .i_pixel_write (o_pix.pixel_write),
    .i_frame_last  (o_pix.frame_last)
);

`default_nettype wire
